/* design/ccah_pkg.sv */
package ccah_pkg;

    typedef enum logic [1:0] {
        OP_CLEAR   = 2'd0,
        OP_CAL     = 2'd1,
        OP_HEADING = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    localparam int unsigned ONE_Q16    = 32'd65536;
    localparam int          TURN       = 23040;
    localparam int          DECL_LIMIT = 11520;

    // queued item between front and back
    typedef struct packed {
        logic [1:0]         operation;
        logic signed [15:0] x_sample;
        logic signed [15:0] y_sample;
    } item_t;

    // arctangent of 2^-i in 1/65536 degree units
    function automatic logic [21:0] atan_lut(input logic [4:0] i);
        logic [21:0] r;
        begin
            case (i)
                5'd0:  r = 22'd2949120;
                5'd1:  r = 22'd1740967;
                5'd2:  r = 22'd919879;
                5'd3:  r = 22'd466945;
                5'd4:  r = 22'd234379;
                5'd5:  r = 22'd117304;
                5'd6:  r = 22'd58666;
                5'd7:  r = 22'd29335;
                5'd8:  r = 22'd14668;
                5'd9:  r = 22'd7334;
                5'd10: r = 22'd3667;
                5'd11: r = 22'd1833;
                5'd12: r = 22'd917;
                5'd13: r = 22'd458;
                5'd14: r = 22'd229;
                5'd15: r = 22'd115;
                5'd16: r = 22'd57;
                5'd17: r = 22'd29;
                5'd18: r = 22'd14;
                5'd19: r = 22'd7;
                5'd20: r = 22'd4;
                5'd21: r = 22'd2;
                5'd22: r = 22'd1;
                default: r = 22'd0;
            endcase
            return r;
        end
    endfunction

endpackage

/* design/ccah_if.sv */
interface ccah_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         operation;
    logic signed [15:0] x_sample;
    logic signed [15:0] y_sample;
    modport source (output valid, operation, x_sample, y_sample, input ready);
    modport sink (input valid, operation, x_sample, y_sample, output ready);
endinterface

interface ccah_out_if;
    logic               valid;
    logic               ready;
    logic [14:0]        heading;
    logic signed [15:0] offset_x;
    logic signed [15:0] offset_y;
    logic [31:0]        gain_x;
    logic [31:0]        gain_y;
    modport source (output valid, heading, offset_x, offset_y, gain_x, gain_y, input ready);
    modport sink (input valid, heading, offset_x, offset_y, gain_x, gain_y, output ready);
endinterface

/* design/ccah_queue.sv */
module ccah_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ccah_pkg::item_t      in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ccah_pkg::item_t      out_item
);

    // two entry queue between front and back
    ccah_pkg::item_t mem_reg [2];
    logic            wp_reg, rp_reg;
    logic [1:0]      cnt_reg;
    logic            push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_item  = mem_reg[rp_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

/* design/ccah_back.sv */
module ccah_back #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic signed [14:0]    declination,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  ccah_pkg::item_t       in_item,
    ccah_out_if.source            res
);

    localparam int SW = $clog2(CORDIC_STEPS + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_CAL, S_DIV, S_MUL, S_PRE, S_ROT, S_FIN, S_OUT
    } state_t;

    state_t state_reg;
    logic signed [15:0] min_x_reg, max_x_reg, min_y_reg, max_y_reg;
    logic signed [15:0] cx_reg, cy_reg;
    logic [31:0]        sx_reg, sy_reg;
    logic signed [15:0] xs_reg, ys_reg;
    // divider
    logic [16:0]        den_reg;
    logic [32:0]        num_reg;
    logic [33:0]        rem_reg;
    logic [5:0]         dcnt_reg;
    logic               div_y_reg;
    // cordic
    logic signed [52:0] x_reg, y_reg;
    logic signed [27:0] z_reg;
    logic [SW-1:0]      k_reg;
    logic               zero_reg;
    logic [14:0]        head_reg;

    // min/max widening
    logic signed [15:0] nminx, nmaxx, nminy, nmaxy;
    logic signed [16:0] spx, spy, sumx, sumy;
    assign nminx = (xs_reg < min_x_reg) ? xs_reg : min_x_reg;
    assign nmaxx = (xs_reg > max_x_reg) ? xs_reg : max_x_reg;
    assign nminy = (ys_reg < min_y_reg) ? ys_reg : min_y_reg;
    assign nmaxy = (ys_reg > max_y_reg) ? ys_reg : max_y_reg;
    assign spx   = 17'(nmaxx) - 17'(nminx);
    assign spy   = 17'(nmaxy) - 17'(nminy);
    assign sumx  = 17'(nmaxx) + 17'(nminx);
    assign sumy  = 17'(nmaxy) + 17'(nminy);

    // truncating halve toward zero
    function automatic logic signed [15:0] half(input logic signed [16:0] s);
        logic signed [16:0] t;
        begin
            t = s + ((s < 0) ? 17'sd1 : 17'sd0);
            return t[16:1];
        end
    endfunction

    // restoring divide step
    logic [33:0] trial;
    logic [33:0] rsh;
    assign rsh   = {rem_reg[32:0], num_reg[32]};
    assign trial = rsh - {17'd0, den_reg};

    // normalization products, both formed combinationally and registered in S_MUL
    logic signed [16:0] dx, dy;
    logic signed [49:0] px, py;
    assign dx = 17'(xs_reg) - 17'(cx_reg);
    assign dy = 17'(ys_reg) - 17'(cy_reg);
    assign px = dx * $signed({1'b0, sx_reg});
    assign py = dy * $signed({1'b0, sy_reg});

    // cordic step
    logic [4:0]         kk;
    logic signed [52:0] xsh, ysh;
    logic signed [27:0] at;
    assign kk  = 5'(k_reg);
    assign xsh = x_reg >>> kk;
    assign ysh = y_reg >>> kk;
    assign at  = 28'(ccah_pkg::atan_lut(kk));

    // rounding, declination, wrap
    logic signed [27:0] zr;
    logic signed [17:0] h0, h1, h2, dsat;
    assign zr   = (z_reg + 28'sd512) >>> 10;
    assign dsat = (declination > 15'sd11520) ? 18'sd11520 :
                  (declination < -15'sd11520) ? -18'sd11520 : 18'(declination);
    assign h0 = (zero_reg ? 18'sd0 : zr[17:0]) + dsat;
    assign h1 = (h0 < 0) ? h0 + 18'sd23040 : (h0 >= 18'sd23040) ? h0 - 18'sd23040 : h0;
    assign h2 = (h1 < 0) ? h1 + 18'sd23040 : (h1 >= 18'sd23040) ? h1 - 18'sd23040 : h1;

    assign in_ready     = (state_reg == S_IDLE);
    assign res.valid    = (state_reg == S_OUT);
    assign res.heading  = head_reg;
    assign res.offset_x = cx_reg;
    assign res.offset_y = cy_reg;
    assign res.gain_x   = sx_reg;
    assign res.gain_y   = sy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            min_x_reg <= 16'sd32767;
            min_y_reg <= 16'sd32767;
            max_x_reg <= -16'sd32768;
            max_y_reg <= -16'sd32768;
            cx_reg    <= 16'sd24;
            cy_reg    <= 16'sd14;
            sx_reg    <= ccah_pkg::ONE_Q16;
            sy_reg    <= 32'd66992;
            head_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        xs_reg   <= in_item.x_sample;
                        ys_reg   <= in_item.y_sample;
                        head_reg <= '0;
                        case (ccah_pkg::op_t'(in_item.operation))
                            ccah_pkg::OP_CLEAR:
                            begin
                                min_x_reg <= 16'sd32767;
                                min_y_reg <= 16'sd32767;
                                max_x_reg <= -16'sd32768;
                                max_y_reg <= -16'sd32768;
                                cx_reg    <= '0;
                                cy_reg    <= '0;
                                sx_reg    <= ccah_pkg::ONE_Q16;
                                sy_reg    <= ccah_pkg::ONE_Q16;
                                state_reg <= S_OUT;
                            end
                            ccah_pkg::OP_CAL:     state_reg <= S_CAL;
                            ccah_pkg::OP_HEADING: state_reg <= S_MUL;
                            default:              state_reg <= S_OUT;
                        endcase
                    end
                end
                S_CAL:
                begin
                    min_x_reg <= nminx;
                    max_x_reg <= nmaxx;
                    min_y_reg <= nminy;
                    max_y_reg <= nmaxy;
                    cx_reg    <= half(sumx);
                    cy_reg    <= half(sumy);
                    rem_reg   <= '0;
                    dcnt_reg  <= 6'd33;
                    if (spx > spy)
                    begin
                        sx_reg    <= ccah_pkg::ONE_Q16;
                        div_y_reg <= 1'b1;
                        num_reg   <= {spx[16:0], 16'd0};
                        den_reg   <= spy[16:0];
                        if (spy == 0)
                        begin
                            sy_reg    <= ccah_pkg::ONE_Q16;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            state_reg <= S_DIV;
                        end
                    end
                    else
                    begin
                        sy_reg    <= ccah_pkg::ONE_Q16;
                        div_y_reg <= 1'b0;
                        num_reg   <= {spy[16:0], 16'd0};
                        den_reg   <= spx[16:0];
                        if (spx == 0)
                        begin
                            sx_reg    <= ccah_pkg::ONE_Q16;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            state_reg <= S_DIV;
                        end
                    end
                end
                // one quotient bit per cycle
                S_DIV:
                begin
                    num_reg <= {num_reg[31:0], ~trial[33]};
                    rem_reg <= trial[33] ? rsh : trial;
                    dcnt_reg <= dcnt_reg - 6'd1;
                    if (dcnt_reg == 6'd1)
                    begin
                        if (div_y_reg)
                        begin
                            sy_reg <= {num_reg[30:0], ~trial[33]};
                        end
                        else
                        begin
                            sx_reg <= {num_reg[30:0], ~trial[33]};
                        end
                        state_reg <= S_OUT;
                    end
                end
                S_MUL:
                begin
                    x_reg     <= 53'(px);
                    y_reg     <= 53'(py);
                    state_reg <= S_PRE;
                end
                // quadrant fold
                S_PRE:
                begin
                    zero_reg <= (x_reg == 0) && (y_reg == 0);
                    k_reg    <= '0;
                    z_reg    <= '0;
                    if (x_reg < 0)
                    begin
                        if (y_reg >= 0)
                        begin
                            x_reg <= y_reg;
                            y_reg <= -x_reg;
                            z_reg <= 28'sd5898240;
                        end
                        else
                        begin
                            x_reg <= -y_reg;
                            y_reg <= x_reg;
                            z_reg <= -28'sd5898240;
                        end
                    end
                    state_reg <= S_ROT;
                end
                S_ROT:
                begin
                    if (y_reg > 0)
                    begin
                        x_reg <= x_reg + ysh;
                        y_reg <= y_reg - xsh;
                        z_reg <= z_reg + at;
                    end
                    else
                    begin
                        x_reg <= x_reg - ysh;
                        y_reg <= y_reg + xsh;
                        z_reg <= z_reg - at;
                    end
                    k_reg <= k_reg + 1'b1;
                    if (k_reg == SW'(CORDIC_STEPS - 1))
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    head_reg  <= h2[14:0];
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (res.ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

/* design/compass_calibration_and_heading_top.sv */
// Compass calibration and heading: each input beat (clear, calibration sample, heading
// sample or unused code) yields one output beat with the heading and the current offsets and gains.
// Items pass through a two-entry queue into a sequential back end that handles one item at
// a time: clear and unused codes go straight to the output beat, a calibration sample uses
// a 33-step restoring divider for the gain ratio, a heading sample an iterative CORDIC.
// The declination register is written with cfg_we/cfg_data.
module compass_calibration_and_heading_top #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [14:0]  cfg_data,
    ccah_in_if.sink      in_ch,
    ccah_out_if.source   out_ch
);

    logic signed [14:0] decl_reg;
    ccah_pkg::item_t    fin, qout;
    logic               qvalid, qready;

    // declination register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decl_reg <= '0;
        end
        else if (cfg_we)
        begin
            decl_reg <= cfg_data;
        end
    end

    assign fin.operation = in_ch.operation;
    assign fin.x_sample  = in_ch.x_sample;
    assign fin.y_sample  = in_ch.y_sample;

    ccah_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .in_item   (fin),
        .out_valid (qvalid),
        .out_ready (qready),
        .out_item  (qout)
    );

    ccah_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .declination (decl_reg),
        .in_valid    (qvalid),
        .in_ready    (qready),
        .in_item     (qout),
        .res         (out_ch)
    );

endmodule

/* design/ccah_checker.sv */
module ccah_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [14:0] heading,
    input logic [31:0] gain_x,
    input logic [31:0] gain_y
);

    // heading always within one turn
    assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> heading < 15'd23040)
        else $error("heading out of range");

    // one gain is always unity
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (gain_x == 32'd65536 || gain_y == 32'd65536))
        else $error("no unity gain");

    // stalled beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(heading))
        else $error("stalled beat changed");

endmodule

bind compass_calibration_and_heading_top ccah_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .heading   (out_ch.heading),
    .gain_x    (out_ch.gain_x),
    .gain_y    (out_ch.gain_y)
);
